[sv/gdc_pkg.sv]
package gdc_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int ENERGY_BITS_DEF = 24;
  localparam logic [19:0] AMU_RESET = 20'd931494;
  localparam logic [17:0] FACTOR_MAX = 18'h3FFFF;
  localparam logic [15:0] BETA_MAX = 16'hFFFF;
  localparam logic [35:0] TWO_PI_Q32 = 36'h6487ED511;
  localparam int RECIP_SHIFT = 40;
  localparam int SC_LAT = 13;

  typedef logic signed [31:0] q30_t;

  // signed q.30 product, truncated toward zero
  function automatic q30_t mul30(q30_t a, q30_t b);
    logic [30:0] ua;
    logic [30:0] ub;
    logic [61:0] p;
    logic [31:0] pm;
    ua = a[31] ? 31'(-a) : 31'(a);
    ub = b[31] ? 31'(-b) : 31'(b);
    p = 62'(ua) * 62'(ub);
    pm = 32'(p >> 30);
    mul30 = (a[31] ^ b[31]) ? q30_t'(-pm) : q30_t'(pm);
  endfunction

endpackage

[sv/gdc_taylor_cell.sv]
module gdc_taylor_cell
  import gdc_pkg::*;
#(
  parameter int DIVISOR = 6,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   x2_i,
  input  logic [32:0]   t_i,
  input  logic [SW-1:0] side_i,
  output logic [31:0]   x2_o,
  output logic [32:0]   t_o,
  output logic [SW-1:0] side_o
);

  localparam logic [40:0] RECIP = 41'((64'd1 << RECIP_SHIFT) / DIVISOR + 1);

  logic [31:0]   p_nxt, p_r, x2a_r, x2b_r, q_nxt;
  logic [32:0]   t_nxt, t_r;
  logic [SW-1:0] sidea_r, sideb_r;

  assign p_nxt = 32'((65'(x2_i) * 65'(t_i)) >> 32);
  // floor division by a constant through its reciprocal
  assign q_nxt = 32'((73'(p_r) * 73'(RECIP)) >> RECIP_SHIFT);
  assign t_nxt = 33'h1_0000_0000 - 33'(q_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      x2a_r   <= x2_i;
      sidea_r <= side_i;
      t_r     <= t_nxt;
      x2b_r   <= x2a_r;
      sideb_r <= sidea_r;
    end
  end

  assign x2_o   = x2b_r;
  assign t_o    = t_r;
  assign side_o = sideb_r;

endmodule

[sv/gdc_sincos.sv]
module gdc_sincos
  import gdc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] turn_i,
  output q30_t        sin_o,
  output q30_t        cos_o
);

  localparam int SIN_CELLS = 4;
  localparam int COS_CELLS = 5;

  // series divisors, innermost term first
  function automatic int sin_div(int i);
    case (i)
      0: return 72;
      1: return 42;
      2: return 20;
      default: return 6;
    endcase
  endfunction

  function automatic int cos_div(int i);
    case (i)
      0: return 90;
      1: return 56;
      2: return 30;
      3: return 12;
      default: return 2;
    endcase
  endfunction

  logic [29:0] r_nxt;
  logic [31:0] x_nxt, x_r, xs_r, x2_nxt, x2_r;
  logic [2:0]  oct1_r, oct2_r;

  logic [31:0] sx2 [0:SIN_CELLS];
  logic [32:0] st  [0:SIN_CELLS];
  logic [31:0] sx  [0:SIN_CELLS];
  logic [31:0] cx2 [0:COS_CELLS];
  logic [32:0] ct  [0:COS_CELLS];
  logic [2:0]  co  [0:COS_CELLS];

  logic [31:0] sn_nxt, sn1_r, sn2_r;
  logic [32:0] sv, cv;
  q30_t        ss, cc, s_nxt, c_nxt, s_r, c_r;

  // fold into the first octant
  assign r_nxt = turn_i[29] ? 30'h2000_0000 - {1'b0, turn_i[28:0]} : {1'b0, turn_i[28:0]};
  assign x_nxt  = 32'((66'(r_nxt) * 66'(TWO_PI_Q32)) >> 32);
  assign x2_nxt = 32'((64'(x_r) * 64'(x_r)) >> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      oct1_r <= turn_i[31:29];
      x2_r   <= x2_nxt;
      xs_r   <= x_r;
      oct2_r <= oct1_r;
    end
  end

  assign sx2[0] = x2_r;
  assign st[0]  = 33'h1_0000_0000;
  assign sx[0]  = xs_r;
  assign cx2[0] = x2_r;
  assign ct[0]  = 33'h1_0000_0000;
  assign co[0]  = oct2_r;

  for (genvar i = 0; i < SIN_CELLS; i++) begin : g_sin
    gdc_taylor_cell #(.DIVISOR(sin_div(i)), .SW(32)) u_cell (
      .clk(clk), .en(en),
      .x2_i(sx2[i]), .t_i(st[i]), .side_i(sx[i]),
      .x2_o(sx2[i+1]), .t_o(st[i+1]), .side_o(sx[i+1])
    );
  end

  for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos
    gdc_taylor_cell #(.DIVISOR(cos_div(i)), .SW(3)) u_cell (
      .clk(clk), .en(en),
      .x2_i(cx2[i]), .t_i(ct[i]), .side_i(co[i]),
      .x2_o(cx2[i+1]), .t_o(ct[i+1]), .side_o(co[i+1])
    );
  end

  assign sn_nxt = 32'((65'(sx[SIN_CELLS]) * 65'(st[SIN_CELLS])) >> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      sn1_r <= sn_nxt;
      sn2_r <= sn1_r;
    end
  end

  assign sv = co[COS_CELLS][0] ? ct[COS_CELLS] : {1'b0, sn2_r};
  assign cv = co[COS_CELLS][0] ? {1'b0, sn2_r} : ct[COS_CELLS];
  assign ss = q30_t'(sv >> 2);
  assign cc = q30_t'(cv >> 2);

  always_comb begin
    case (co[COS_CELLS][2:1])
      2'd0: begin
        s_nxt = ss;
        c_nxt = cc;
      end
      2'd1: begin
        s_nxt = cc;
        c_nxt = -ss;
      end
      2'd2: begin
        s_nxt = -ss;
        c_nxt = -cc;
      end
      default: begin
        s_nxt = -cc;
        c_nxt = ss;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  assign sin_o = s_r;
  assign cos_o = c_r;

endmodule

[sv/gdc_sqrt_cell.sv]
module gdc_sqrt_cell #(
  parameter int W = 64,
  parameter int BIT = 0,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   rem_i,
  input  logic [W/2-1:0] root_i,
  input  logic [SW-1:0]  side_i,
  output logic [W-1:0]   rem_o,
  output logic [W/2-1:0] root_o,
  output logic [SW-1:0]  side_o
);

  localparam int TW = W + 2;

  logic [TW-1:0]  trial;
  logic           ge;
  logic [W-1:0]   rem_nxt, rem_r;
  logic [W/2-1:0] root_nxt, root_r;
  logic [SW-1:0]  side_r;

  assign trial    = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign ge       = TW'(rem_i) >= trial;
  assign rem_nxt  = ge ? W'(TW'(rem_i) - trial) : rem_i;
  assign root_nxt = root_i | ((W/2)'(ge) << BIT);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

[sv/gdc_div_cell.sv]
module gdc_div_cell #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  input  logic [QW-1:0] nb_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] q_o,
  output logic [QW-1:0] nb_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   t, diff;
  logic          ge;
  logic [DW-1:0] rem_nxt, rem_r, den_r;
  logic [QW-1:0] q_nxt, q_r, nb_nxt, nb_r;
  logic [SW-1:0] side_r;

  assign t       = {rem_i, nb_i[QW-1]};
  assign ge      = t >= {1'b0, den_i};
  assign diff    = t - {1'b0, den_i};
  assign rem_nxt = ge ? diff[DW-1:0] : t[DW-1:0];
  assign q_nxt   = {q_i[QW-2:0], ge};
  assign nb_nxt  = {nb_i[QW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      q_r    <= q_nxt;
      nb_r   <= nb_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign q_o    = q_r;
  assign nb_o   = nb_r;
  assign side_o = side_r;

endmodule

[sv/gamma_doppler_correction_top.sv]
// throughput: one beat per cycle; the whole pipeline holds while a result beat is stalled
// the pipeline length is set by three 32-cell square root chains, two long division chains
// (32 and 18 cells) and the series evaluation of the angle terms running beside them
// reset: synchronous active-low rst_n clears all valid bits and loads the mass unit
// register with 931494 keV
module gamma_doppler_correction_top
  import gdc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ENERGY_BITS-1:0] in_particle_energy_kev,
  input  logic [8:0]             in_mass_number,
  input  logic [ANGLE_BITS-1:0]  in_particle_theta,
  input  logic [ANGLE_BITS-1:0]  in_particle_phi,
  input  logic [ANGLE_BITS-1:0]  in_photon_theta,
  input  logic [ANGLE_BITS-1:0]  in_photon_phi,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [17:0]            out_correction_factor,
  output logic [15:0]            out_particle_beta,
  output logic                   out_saturated,
  input  logic                   cfg_we,
  input  logic [19:0]            cfg_wdata
);

  localparam int SQ = 32;
  localparam int DQ = 32;
  localparam int FQ = 18;
  localparam int SUMW = (ENERGY_BITS + 4 > 30) ? ENERGY_BITS + 4 : 30;
  localparam int ANG_IDX = 1 + SC_LAT + 3;
  localparam int COS_DLY = 3 + SQ + DQ - ANG_IDX;
  localparam int LAT = 4 + SQ + DQ + SQ + 3 + FQ;

  logic           en, accept;
  logic [LAT:1]   vld_r;
  logic [19:0]    amu_r;

  assign en       = !(vld_r[LAT] && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign out_valid = vld_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      amu_r <= AMU_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-1:1], accept};
      end
      if (cfg_we) begin
        amu_r <= cfg_wdata;
      end
    end
  end

  // input stage
  logic [28:0]            m0_r;
  logic [ENERGY_BITS-1:0] e0_r;
  logic [31:0]            tpt_r, tgt_r, tdp_r, tpp, tgp;

  assign tpp = 32'(in_particle_phi) << (32 - ANGLE_BITS);
  assign tgp = 32'(in_photon_phi) << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r  <= 29'(in_mass_number) * 29'(amu_r);
      e0_r  <= in_particle_energy_kev;
      tpt_r <= 32'(in_particle_theta) << (32 - ANGLE_BITS);
      tgt_r <= 32'(in_photon_theta) << (32 - ANGLE_BITS);
      tdp_r <= tpp - tgp;
    end
  end

  // m * (m + 6e)
  logic [SUMW-1:0]    sum1;
  logic [28+SUMW:0]   prod1;
  logic [63:0]        v1_r;
  logic [28:0]        m1_r;

  assign sum1  = SUMW'(m0_r) + SUMW'(e0_r) * SUMW'(6);
  assign prod1 = (29+SUMW)'(m0_r) * (29+SUMW)'(sum1);

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= 64'(prod1);
      m1_r <= m0_r;
    end
  end

  logic [63:0] s1_rem  [0:SQ];
  logic [31:0] s1_root [0:SQ];
  logic [28:0] s1_m    [0:SQ];

  assign s1_rem[0]  = v1_r;
  assign s1_root[0] = '0;
  assign s1_m[0]    = m1_r;

  for (genvar i = 0; i < SQ; i++) begin : g_sq1
    gdc_sqrt_cell #(.W(64), .BIT(SQ - 1 - i), .SW(29)) u_cell (
      .clk(clk), .en(en),
      .rem_i(s1_rem[i]), .root_i(s1_root[i]), .side_i(s1_m[i]),
      .rem_o(s1_rem[i+1]), .root_o(s1_root[i+1]), .side_o(s1_m[i+1])
    );
  end

  // beta squared numerator and limit check
  logic [33:0] num2;
  logic [30:0] m3;
  logic        sat2;
  logic [30:0] d1rem_r, d1den_r;
  logic        sat2_r;

  assign num2 = {1'b0, s1_root[SQ], 1'b0} - {4'b0, s1_m[SQ], 1'b0};
  assign m3   = 31'({s1_m[SQ], 1'b0}) + 31'(s1_m[SQ]);
  assign sat2 = (s1_m[SQ] == '0) || (num2 >= 34'(m3));

  always_ff @(posedge clk) begin
    if (en) begin
      d1rem_r <= num2[30:0];
      d1den_r <= m3;
      sat2_r  <= sat2;
    end
  end

  logic [30:0] d1_rem [0:DQ];
  logic [30:0] d1_den [0:DQ];
  logic [31:0] d1_q   [0:DQ];
  logic [31:0] d1_nb  [0:DQ];
  logic        d1_sat [0:DQ];

  assign d1_rem[0] = d1rem_r;
  assign d1_den[0] = d1den_r;
  assign d1_q[0]   = '0;
  assign d1_nb[0]  = '0;
  assign d1_sat[0] = sat2_r;

  for (genvar i = 0; i < DQ; i++) begin : g_div1
    gdc_div_cell #(.DW(31), .QW(32), .SW(1)) u_cell (
      .clk(clk), .en(en),
      .rem_i(d1_rem[i]), .den_i(d1_den[i]), .q_i(d1_q[i]), .nb_i(d1_nb[i]),
      .side_i(d1_sat[i]),
      .rem_o(d1_rem[i+1]), .den_o(d1_den[i+1]), .q_o(d1_q[i+1]), .nb_o(d1_nb[i+1]),
      .side_o(d1_sat[i+1])
    );
  end

  // angle path
  q30_t spt, cpt, sgt, cgt, cdp;
  q30_t m1_nxt, m2_nxt, m1a_r, m2a_r, cdpa_r, m3_nxt, m3b_r, m2b_r, cosc_nxt, cosc_r;
  logic signed [32:0] csum;
  q30_t cdly_r [1:COS_DLY];

  gdc_sincos u_sc_pt (.clk(clk), .en(en), .turn_i(tpt_r), .sin_o(spt), .cos_o(cpt));
  gdc_sincos u_sc_gt (.clk(clk), .en(en), .turn_i(tgt_r), .sin_o(sgt), .cos_o(cgt));
  gdc_sincos u_sc_dp (.clk(clk), .en(en), .turn_i(tdp_r), .sin_o(), .cos_o(cdp));

  assign m1_nxt = mul30(spt, sgt);
  assign m2_nxt = mul30(cpt, cgt);
  assign m3_nxt = mul30(m1a_r, cdpa_r);
  assign csum   = 33'(m3b_r) + 33'(m2b_r);

  always_comb begin
    if (csum > 33'sd1073741824) begin
      cosc_nxt = 32'sd1073741824;
    end else if (csum < -33'sd1073741824) begin
      cosc_nxt = -32'sd1073741824;
    end else begin
      cosc_nxt = q30_t'(csum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1a_r  <= m1_nxt;
      m2a_r  <= m2_nxt;
      cdpa_r <= cdp;
      m3b_r  <= m3_nxt;
      m2b_r  <= m2a_r;
      cosc_r <= cosc_nxt;
      cdly_r[1] <= cosc_r;
      for (int k = 2; k <= COS_DLY; k++) begin
        cdly_r[k] <= cdly_r[k-1];
      end
    end
  end

  // square root arguments for beta and 1/gamma
  logic [63:0] vb3_r, vd3_r;
  logic        sat3_r;
  q30_t        cos3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vb3_r  <= 64'(d1_q[DQ]);
      vd3_r  <= 64'(33'h1_0000_0000 - 33'(d1_q[DQ])) << 30;
      sat3_r <= d1_sat[DQ];
      cos3_r <= cdly_r[COS_DLY];
    end
  end

  logic [63:0] sb_rem  [0:SQ];
  logic [31:0] sb_root [0:SQ];
  logic        sb_sat  [0:SQ];
  logic [63:0] sd_rem  [0:SQ];
  logic [31:0] sd_root [0:SQ];
  q30_t        sd_cos  [0:SQ];

  assign sb_rem[0]  = vb3_r;
  assign sb_root[0] = '0;
  assign sb_sat[0]  = sat3_r;
  assign sd_rem[0]  = vd3_r;
  assign sd_root[0] = '0;
  assign sd_cos[0]  = cos3_r;

  for (genvar i = 0; i < SQ; i++) begin : g_sq2
    gdc_sqrt_cell #(.W(64), .BIT(SQ - 1 - i), .SW(1)) u_beta (
      .clk(clk), .en(en),
      .rem_i(sb_rem[i]), .root_i(sb_root[i]), .side_i(sb_sat[i]),
      .rem_o(sb_rem[i+1]), .root_o(sb_root[i+1]), .side_o(sb_sat[i+1])
    );
    gdc_sqrt_cell #(.W(64), .BIT(SQ - 1 - i), .SW(32)) u_den (
      .clk(clk), .en(en),
      .rem_i(sd_rem[i]), .root_i(sd_root[i]), .side_i(sd_cos[i]),
      .rem_o(sd_rem[i+1]), .root_o(sd_root[i+1]), .side_o(sd_cos[i+1])
    );
  end

  // 1 - beta * cos
  logic [15:0] beta4;
  logic [30:0] ucos;
  logic [32:0] p4;
  logic [33:0] n4_r;
  logic [31:0] d4_r;
  logic [15:0] beta4_r;
  logic        sat4_r;

  assign beta4 = sb_root[SQ][15:0];
  assign ucos  = sd_cos[SQ][31] ? 31'(-sd_cos[SQ]) : 31'(sd_cos[SQ]);
  assign p4    = 33'((47'(beta4) * 47'(ucos)) >> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r    <= sd_cos[SQ][31] ? 34'h1_0000_0000 + 34'(p4) : 34'h1_0000_0000 - 34'(p4);
      d4_r    <= sd_root[SQ];
      beta4_r <= beta4;
      sat4_r  <= sb_sat[SQ];
    end
  end

  // overflow check, then the low quotient bits
  logic [31:0] d2rem_r, d2den_r;
  logic [17:0] d2nb_r;
  logic [17:0] d2side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d2rem_r  <= 32'(n4_r[33:3]);
      d2den_r  <= d4_r;
      d2nb_r   <= {n4_r[2:0], 15'b0};
      d2side_r <= {sat4_r, (35'(n4_r) >= {d4_r, 3'b0}), beta4_r};
    end
  end

  logic [31:0] d2_rem  [0:FQ];
  logic [31:0] d2_den  [0:FQ];
  logic [17:0] d2_q    [0:FQ];
  logic [17:0] d2_nb   [0:FQ];
  logic [17:0] d2_side [0:FQ];

  assign d2_rem[0]  = d2rem_r;
  assign d2_den[0]  = d2den_r;
  assign d2_q[0]    = '0;
  assign d2_nb[0]   = d2nb_r;
  assign d2_side[0] = d2side_r;

  for (genvar i = 0; i < FQ; i++) begin : g_div2
    gdc_div_cell #(.DW(32), .QW(18), .SW(18)) u_cell (
      .clk(clk), .en(en),
      .rem_i(d2_rem[i]), .den_i(d2_den[i]), .q_i(d2_q[i]), .nb_i(d2_nb[i]),
      .side_i(d2_side[i]),
      .rem_o(d2_rem[i+1]), .den_o(d2_den[i+1]), .q_o(d2_q[i+1]), .nb_o(d2_nb[i+1]),
      .side_o(d2_side[i+1])
    );
  end

  // result register
  logic        sat6, ovf6;
  logic [17:0] factor_r;
  logic [15:0] beta_r;
  logic        satd_r;

  assign sat6 = d2_side[FQ][17];
  assign ovf6 = d2_side[FQ][16];

  always_ff @(posedge clk) begin
    if (en) begin
      factor_r <= (sat6 || ovf6) ? FACTOR_MAX : d2_q[FQ];
      beta_r   <= sat6 ? BETA_MAX : d2_side[FQ][15:0];
      satd_r   <= sat6 || ovf6;
    end
  end

  assign out_correction_factor = factor_r;
  assign out_particle_beta     = beta_r;
  assign out_saturated         = satd_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_correction_factor))
    else $error("stalled result beat lost or changed");

  a_pipe_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while held");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && en |=> vld_r[1] == $past(in_valid && !in_stall))
    else $error("accepted beat not entered into pipeline");

endmodule

[tb/tb_gamma_doppler_correction_top.sv]
module tb_gamma_doppler_correction_top;
  import gdc_pkg::*;

  typedef struct packed {
    logic [23:0] energy;
    logic [8:0]  mass;
    logic [15:0] p_theta;
    logic [15:0] p_phi;
    logic [15:0] g_theta;
    logic [15:0] g_phi;
  } pair_t;

  typedef struct packed {
    logic [17:0] factor;
    logic [15:0] beta;
    logic        sat;
  } doppler_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [23:0] in_particle_energy_kev;
  logic [8:0] in_mass_number;
  logic [15:0] in_particle_theta;
  logic [15:0] in_particle_phi;
  logic [15:0] in_photon_theta;
  logic [15:0] in_photon_phi;
  logic out_valid;
  logic out_stall;
  logic [17:0] out_correction_factor;
  logic [15:0] out_particle_beta;
  logic out_saturated;
  logic cfg_we;
  logic [19:0] cfg_wdata;

  pair_t pending_pairs[$];
  doppler_t expected_factors[$];
  logic [19:0] amu_kev;
  int errors;
  int tx_gap;
  int rx_gap;
  int rx_hold;
  bit idle_on;

  gamma_doppler_correction_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_particle_energy_kev(in_particle_energy_kev),
    .in_mass_number(in_mass_number),
    .in_particle_theta(in_particle_theta),
    .in_particle_phi(in_particle_phi),
    .in_photon_theta(in_photon_theta),
    .in_photon_phi(in_photon_phi),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_correction_factor(out_correction_factor),
    .out_particle_beta(out_particle_beta),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void turn_sin_cos(logic [31:0] a, output longint s, output longint c);
    logic [2:0] oct;
    logic [63:0] r, x, x2, t, sn, cs, tmp;
    longint ss, cc;
    oct = a[31:29];
    r = {35'd0, a[28:0]};
    if (oct[0]) r = 64'h2000_0000 - r;
    x = (r * 64'(TWO_PI_Q32)) >> 32;
    x2 = (x * x) >> 32;
    t = (64'd1 << 32) - x2 / 72;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 42;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 20;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 6;
    sn = (x * t) >> 32;
    t = (64'd1 << 32) - x2 / 90;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 56;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 30;
    t = (64'd1 << 32) - ((x2 * t) >> 32) / 12;
    cs = (64'd1 << 32) - ((x2 * t) >> 32) / 2;
    if (oct[0]) begin
      tmp = sn;
      sn = cs;
      cs = tmp;
    end
    ss = longint'(sn >> 2);
    cc = longint'(cs >> 2);
    case (oct[2:1])
      2'd0: begin s = ss; c = cc; end
      2'd1: begin s = cc; c = -ss; end
      2'd2: begin s = -ss; c = -cc; end
      default: begin s = -cc; c = ss; end
    endcase
  endfunction

  function automatic longint q30_mult(longint a, longint b);
    logic [63:0] ua, ub, p;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = (ua * ub) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic doppler_t doppler_factor(pair_t p, logic [19:0] amu);
    doppler_t res;
    logic [63:0] m, e, s, num, b2, beta, ucos, prod, n, d, f;
    longint spt, cpt, sgt, cgt, sdp, cdp, cosang;
    m = 64'(p.mass) * 64'(amu);
    e = 64'(p.energy);
    res = '{factor: FACTOR_MAX, beta: BETA_MAX, sat: 1'b1};
    if (m == 0) return res;
    s = int_sqrt(m * (m + 6 * e));
    num = 2 * (s - m);
    if (num >= 3 * m) return res;
    b2 = (num << 32) / (3 * m);
    beta = int_sqrt(b2);
    turn_sin_cos({p.p_theta, 16'd0}, spt, cpt);
    turn_sin_cos({p.g_theta, 16'd0}, sgt, cgt);
    turn_sin_cos({p.p_phi, 16'd0} - {p.g_phi, 16'd0}, sdp, cdp);
    cosang = q30_mult(q30_mult(spt, sgt), cdp) + q30_mult(cpt, cgt);
    if (cosang > (longint'(1) << 30)) cosang = longint'(1) << 30;
    if (cosang < -(longint'(1) << 30)) cosang = -(longint'(1) << 30);
    ucos = (cosang < 0) ? 64'(-cosang) : 64'(cosang);
    prod = (beta * ucos) >> 14;
    n = (cosang >= 0) ? (64'd1 << 32) - prod : (64'd1 << 32) + prod;
    d = int_sqrt(((64'd1 << 32) - b2) << 30);
    f = (n << 15) / d;
    res.beta = beta[15:0];
    if (f > 64'(FACTOR_MAX)) begin
      res.factor = FACTOR_MAX;
      res.sat = 1'b1;
    end else begin
      res.factor = f[17:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    pair_t nxt;
    logic v_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      v_next = in_valid;
      if (in_valid && !in_stall) begin
        expected_factors.push_back(doppler_factor({in_particle_energy_kev, in_mass_number,
          in_particle_theta, in_particle_phi, in_photon_theta, in_photon_phi}, amu_kev));
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_pairs.size() > 0) begin
          nxt = pending_pairs.pop_front();
          in_particle_energy_kev <= nxt.energy;
          in_mass_number <= nxt.mass;
          in_particle_theta <= nxt.p_theta;
          in_particle_phi <= nxt.p_phi;
          in_photon_theta <= nxt.g_theta;
          in_photon_phi <= nxt.g_phi;
          v_next = 1'b1;
          tx_gap <= idle_on ? pick_gap() : 0;
        end
      end
      in_valid <= v_next;
    end
  end

  // receiver
  always @(posedge clk) begin
    doppler_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_factors.size() == 0) begin
          report_mismatch("unexpected beat, factor", out_correction_factor, 0);
        end else begin
          want = expected_factors.pop_front();
          if (out_correction_factor !== want.factor)
            report_mismatch("factor", out_correction_factor, want.factor);
          if (out_particle_beta !== want.beta)
            report_mismatch("beta", out_particle_beta, want.beta);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap <= idle_on ? pick_gap() : 0;
      end
    end
  end

  task automatic add_pair(logic [23:0] e, logic [8:0] a, logic [15:0] pt, logic [15:0] pp,
                          logic [15:0] gt, logic [15:0] gp);
    pending_pairs.push_back('{e, a, pt, pp, gt, gp});
  endtask

  task automatic write_amu(logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    amu_kev = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_factors.size() == 0);
    repeat (130) @(posedge clk);
  endtask

  task automatic add_random(int count);
    logic [23:0] e;
    logic [8:0] a;
    logic [63:0] lim;
    repeat (count) begin
      a = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 300));
      case ($urandom_range(0, 3))
        0: e = 24'($urandom) >> $urandom_range(0, 23);
        1: e = 24'($urandom);
        default: begin
          // energies near where beta squared approaches one
          lim = (64'(a) * 64'(amu_kev) * 7) / 8;
          lim = lim + $urandom_range(0, 40000) - 30000;
          e = (lim > 64'hFFFFFF) ? 24'($urandom) : lim[23:0];
        end
      endcase
      add_pair(e, a, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [19:0] amu_settings[5];
    amu_settings = '{20'd931494, 20'd900000, 20'd1000000, 20'hFFFFF, 20'd0};
    errors = 0;
    rx_hold = 0;
    idle_on = 1'b1;
    amu_kev = AMU_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_particle_energy_kev = '0;
    in_mass_number = '0;
    in_particle_theta = '0;
    in_particle_phi = '0;
    in_photon_theta = '0;
    in_photon_phi = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    add_pair(24'd0, 9'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    add_pair(24'hFFFFFF, 9'd300, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pair(24'd1000, 9'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_pair(24'd1000, 9'd511, 16'h4000, 16'h0000, 16'h4000, 16'h8000);
    add_pair(24'd815057, 9'd1, 16'h1000, 16'h2000, 16'h3000, 16'h4000);
    add_pair(24'hFFFFFF, 9'd1, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
    add_pair(24'd800000, 9'd1, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
    add_pair(24'd780000, 9'd1, 16'h4000, 16'h0000, 16'h4000, 16'h8000);
    add_pair(24'd500000, 9'd1, 16'h4000, 16'h0000, 16'h4000, 16'h0000);
    add_pair(24'd100000, 9'd12, 16'h2000, 16'hC000, 16'h6000, 16'h4000);
    add_pair(24'd1, 9'd300, 16'h8000, 16'h5555, 16'hAAAA, 16'h1234);
    add_pair(24'd50000, 9'd100, 16'hE000, 16'hFFFF, 16'h2000, 16'h0001);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_amu(amu_settings[ph]);
      idle_on = (ph != 1);
      if (ph == 2) rx_hold = 400;
      add_random(100);
      drain();
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
sv/gdc_pkg.sv
sv/gdc_taylor_cell.sv
sv/gdc_sincos.sv
sv/gdc_sqrt_cell.sv
sv/gdc_div_cell.sv
sv/gamma_doppler_correction_top.sv
tb/tb_gamma_doppler_correction_top.sv
